FILE: hdl/dwta_pkg.sv
// Shared constants and types for the domain wait-time accumulator.
package dwta_pkg;

	localparam int DOM_W       = 15;
	localparam int TIME_W      = 64;
	localparam int MAX_DOMAINS = 32;
	localparam int SLOT_W      = 5;
	localparam int CNT_W       = 6;
	localparam int NUM_BUCKETS = 10;
	localparam int NUM_BINS    = NUM_BUCKETS + 1;
	localparam int BKT_W       = 4;
	localparam int HCNT_W      = 32;
	localparam int BWID_W      = 32;
	localparam int THR_W       = BWID_W + BKT_W;

	localparam logic [DOM_W-1:0]  IDLE_DOMAIN      = 15'h7fff;
	localparam logic [BWID_W-1:0] BUCKET_WIDTH_RST = 32'd7000000;

	// One table entry: domain id and its running wait sum.
	typedef struct packed {
		logic [DOM_W-1:0]  domain;
		logic [TIME_W-1:0] sum;
	} entry_t;

	// Status of the bucket unit.
	typedef struct packed {
		logic             done;
		logic [BKT_W-1:0] bucket;
	} bkt_res_t;

endpackage

FILE: hdl/dwta_if.sv
// Channel interfaces: switch events in, results out, bucket width writes.
interface dwta_in_if import dwta_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DOM_W-1:0]  domain_id;
	logic              wake_pending;
	logic [TIME_W-1:0] switch_ns;
	logic [TIME_W-1:0] wake_ns;

	modport source (output valid, domain_id, wake_pending, switch_ns, wake_ns, input ready);
	modport sink   (input valid, domain_id, wake_pending, switch_ns, wake_ns, output ready);
endinterface

interface dwta_out_if import dwta_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     recorded;
	logic                     table_full_drop;
	logic signed [TIME_W-1:0] wait_ns;
	logic [SLOT_W-1:0]        slot;
	logic [TIME_W-1:0]        domain_total;
	logic [TIME_W-1:0]        grand_total;
	logic [BKT_W-1:0]         bucket;
	logic [HCNT_W-1:0]        bucket_count;
	logic [CNT_W-1:0]         domains_seen;

	modport source (output valid, recorded, table_full_drop, wait_ns, slot, domain_total,
		grand_total, bucket, bucket_count, domains_seen, input ready);
	modport sink   (input valid, recorded, table_full_drop, wait_ns, slot, domain_total,
		grand_total, bucket, bucket_count, domains_seen, output ready);
endinterface

interface dwta_cfg_if import dwta_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BWID_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/dwta_table.sv
// Domain table memory: one write port, one registered read port.
module dwta_table import dwta_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic [SLOT_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [MAX_DOMAINS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/dwta_bucket.sv
// Iterative bucket finder: steps a threshold by the bucket width, one compare a cycle.
module dwta_bucket import dwta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] wait_val,
	input  logic [BWID_W-1:0] width,
	output bkt_res_t          res
);

	logic              busy_q;
	logic              done_q;
	logic [BKT_W-1:0]  k_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [THR_W-1:0]  thr_q;
	logic [THR_W-1:0]  width_q;
	logic [TIME_W-1:0] wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// Negative waits, hits and the last bucket all end the search.
				if (wait_q[TIME_W-1] || (wait_q < TIME_W'(thr_q))
						|| (k_q == BKT_W'(NUM_BUCKETS - 1))) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			wait_q  <= wait_val;
			width_q <= THR_W'(width);
			thr_q   <= THR_W'(width);
			k_q     <= '0;
		end else if (busy_q) begin
			priority if (wait_q[TIME_W-1]) begin
				bucket_q <= BKT_W'(NUM_BUCKETS);
			end else if (wait_q < TIME_W'(thr_q)) begin
				bucket_q <= k_q;
			end else if (k_q == BKT_W'(NUM_BUCKETS - 1)) begin
				bucket_q <= BKT_W'(NUM_BUCKETS);
			end else begin
				thr_q <= thr_q + width_q;
				k_q   <= k_q + 1'b1;
			end
		end
	end

	assign res.done   = done_q;
	assign res.bucket = bucket_q;

endmodule

FILE: hdl/domain_wait_time_accumulator.sv
// Top level: event sequencer, table search, totals, histogram and result register.
//
// Takes one switch event at a time; item_in.ready is high only while the sequencer
// is idle, and a new event may be taken while the last result still waits.
// An idle-domain or no-wake event goes straight to the finish state. Otherwise the
// table search reads one entry at a time through the table's registered read port,
// a read state then a compare state per entry, until a match or, for a new domain,
// the index reaches the count held; then an update state and the bucket unit, which
// steps a threshold by the bucket width once per cycle, then the finish state.
// The finish cycle holds for as long as the previous result still waits.
// A new domain with the table full is dropped and goes straight to the finish state.
module domain_wait_time_accumulator import dwta_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	dwta_in_if.sink        item_in,
	dwta_out_if.source     result_out,
	dwta_cfg_if.sink       cfg
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_CMP  = 7'b0000100,
		S_INS  = 7'b0001000,
		S_UPD  = 7'b0010000,
		S_BKT  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [BWID_W-1:0] bwidth_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [TIME_W-1:0] total_q;
	logic [HCNT_W-1:0] hist_q [NUM_BINS];
	logic              ov_q;

	logic [DOM_W-1:0]  dom_q;
	logic [TIME_W-1:0] wait_q;
	logic [TIME_W-1:0] sum_q;
	logic [SLOT_W-1:0] slot_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [HCNT_W-1:0] bcount_q;
	logic              rec_q;
	logic              drop_q;

	logic              in_acc;
	logic              out_load;
	logic              tbl_we;
	entry_t            tbl_wdata;
	entry_t            tbl_rdata;
	logic              bkt_start;
	bkt_res_t          bkt_res;
	logic [HCNT_W-1:0] hist_inc;

	assign item_in.ready = (state_q == S_IDLE);
	assign in_acc        = item_in.valid && item_in.ready;
	assign cfg.ready     = 1'b1;
	assign out_load      = (state_q == S_FIN) && (!ov_q || result_out.ready);
	assign tbl_we        = (state_q == S_UPD);
	assign bkt_start     = (state_q == S_UPD);
	assign tbl_wdata     = '{domain: dom_q, sum: sum_q};
	assign hist_inc      = hist_q[bkt_res.bucket] + 1'b1;

	dwta_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (slot_q),
		.wdata (tbl_wdata),
		.raddr (idx_q[SLOT_W-1:0]),
		.rdata (tbl_rdata)
	);

	dwta_bucket u_bucket (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (bkt_start),
		.wait_val (wait_q),
		.width    (bwidth_q),
		.res      (bkt_res)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bwidth_q <= BUCKET_WIDTH_RST;
			count_q  <= '0;
			idx_q    <= '0;
			total_q  <= '0;
			ov_q     <= 1'b0;
			for (int i = 0; i < NUM_BINS; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				bwidth_q <= cfg.data;
			end
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (result_out.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q <= '0;
						if ((item_in.domain_id == IDLE_DOMAIN) || !item_in.wake_pending) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= (idx_q == count_q) ? S_INS : S_CMP;
				end
				S_CMP: begin
					if (tbl_rdata.domain == dom_q) begin
						state_q <= S_UPD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_INS: begin
					if (count_q == CNT_W'(MAX_DOMAINS)) begin
						state_q <= S_FIN;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					total_q <= total_q + wait_q;
					state_q <= S_BKT;
				end
				S_BKT: begin
					if (bkt_res.done) begin
						hist_q[bkt_res.bucket] <= hist_inc;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Event payload and working registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					dom_q  <= item_in.domain_id;
					wait_q <= item_in.switch_ns - item_in.wake_ns;
					rec_q  <= 1'b0;
					drop_q <= 1'b0;
				end
			end
			S_CMP: begin
				if (tbl_rdata.domain == dom_q) begin
					slot_q <= idx_q[SLOT_W-1:0];
					sum_q  <= tbl_rdata.sum + wait_q;
				end
			end
			S_INS: begin
				if (count_q == CNT_W'(MAX_DOMAINS)) begin
					drop_q <= 1'b1;
				end else begin
					slot_q <= count_q[SLOT_W-1:0];
					sum_q  <= wait_q;
				end
			end
			S_UPD: begin
				rec_q <= 1'b1;
			end
			S_BKT: begin
				if (bkt_res.done) begin
					bkt_q    <= bkt_res.bucket;
					bcount_q <= hist_inc;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register; unrecorded events zero wait, slot, domain total and bucket fields.
	always_ff @(posedge clk) begin
		if (out_load) begin
			result_out.recorded        <= rec_q;
			result_out.table_full_drop <= drop_q;
			result_out.wait_ns         <= rec_q ? $signed(wait_q) : '0;
			result_out.slot            <= rec_q ? slot_q : '0;
			result_out.domain_total    <= rec_q ? sum_q : '0;
			result_out.grand_total     <= total_q;
			result_out.bucket          <= rec_q ? bkt_q : '0;
			result_out.bucket_count    <= rec_q ? bcount_q : '0;
			result_out.domains_seen    <= count_q;
		end
	end

	assign result_out.valid = ov_q;

endmodule
